// File: sv/scpp_pkg.sv
// ----------------------------------------------------------------------------
// scpp_pkg: shared types, codes and step functions
// Parse state, result record, command trie and the per-byte step function.
// ----------------------------------------------------------------------------
package scpp_pkg;

    // parse phases
    localparam logic [2:0] PH_ID_FIRST  = 3'd0;
    localparam logic [2:0] PH_ID        = 3'd1;
    localparam logic [2:0] PH_TRIE      = 3'd2;
    localparam logic [2:0] PH_AFTER     = 3'd3;
    localparam logic [2:0] PH_VALUE     = 3'd4;
    localparam logic [2:0] PH_END_NOVAL = 3'd5;
    localparam logic [2:0] PH_END_VAL   = 3'd6;

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [6:0]  NODE_COUNT = 7'd37;
    localparam logic [8:0]  ID_LIMIT   = 9'd256;
    localparam logic [31:0] MAG_LIMIT  = 32'h8000_0000;
    localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]  phase;
        logic [6:0]  node;
        logic [8:0]  id_acc;
        logic [31:0] val_acc;
        logic        val_neg;
        logic [5:0]  cmd;
        logic        bad;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:   PH_ID_FIRST,
        node:    7'd0,
        id_acc:  9'd0,
        val_acc: 32'd0,
        val_neg: 1'b0,
        cmd:     6'd0,
        bad:     1'b0
    };

    typedef struct packed {
        logic               ok;
        logic [7:0]         device_id;
        logic [5:0]         command_code;
        logic               value_present;
        logic signed [31:0] argument;
    } scpp_result_t;

    typedef struct packed {
        logic       hit;
        logic       leaf;
        logic [6:0] dest;
    } trie_arc_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] cmd;
    } node_acc_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= 8'h39);
    endfunction

    function automatic trie_arc_t arc_to(input logic [6:0] n);
        trie_arc_t a;
        a.hit  = 1'b1;
        a.leaf = 1'b0;
        a.dest = n;
        return a;
    endfunction

    function automatic trie_arc_t arc_cmd(input logic [5:0] k);
        trie_arc_t a;
        a.hit  = 1'b1;
        a.leaf = 1'b1;
        a.dest = {1'b0, k};
        return a;
    endfunction

    // branch out of a trie node on an uppercase letter
    function automatic trie_arc_t trie_arc(input logic [6:0] node, input logic [7:0] u);
        trie_arc_t a;
        a = '0;
        case ({node, u})
            {7'd0, "L"}:  a = arc_to(7'd1);
            {7'd0, "H"}:  a = arc_cmd(6'd2);
            {7'd0, "O"}:  a = arc_cmd(6'd3);
            {7'd0, "P"}:  a = arc_cmd(6'd4);
            {7'd0, "D"}:  a = arc_to(7'd3);
            {7'd0, "A"}:  a = arc_to(7'd9);
            {7'd0, "M"}:  a = arc_to(7'd10);
            {7'd0, "W"}:  a = arc_to(7'd11);
            {7'd0, "B"}:  a = arc_cmd(6'd12);
            {7'd0, "G"}:  a = arc_cmd(6'd13);
            {7'd0, "S"}:  a = arc_to(7'd12);
            {7'd0, "Q"}:  a = arc_to(7'd13);
            {7'd0, "R"}:  a = arc_to(7'd22);
            {7'd0, "C"}:  a = arc_to(7'd26);
            {7'd1, "E"}:  a = arc_to(7'd2);
            {7'd2, "D"}:  a = arc_cmd(6'd1);
            {7'd3, "E"}:  a = arc_to(7'd4);
            {7'd4, "F"}:  a = arc_to(7'd5);
            {7'd5, "A"}:  a = arc_to(7'd6);
            {7'd6, "U"}:  a = arc_to(7'd7);
            {7'd7, "L"}:  a = arc_to(7'd8);
            {7'd8, "T"}:  a = arc_cmd(6'd6);
            {7'd9, "R"}:  a = arc_cmd(6'd7);
            {7'd9, "S"}:  a = arc_cmd(6'd8);
            {7'd10, "D"}: a = arc_cmd(6'd9);
            {7'd11, "D"}: a = arc_cmd(6'd10);
            {7'd11, "R"}: a = arc_cmd(6'd11);
            {7'd12, "D"}: a = arc_cmd(6'd14);
            {7'd12, "R"}: a = arc_cmd(6'd15);
            {7'd13, "O"}: a = arc_cmd(6'd17);
            {7'd13, "A"}: a = arc_to(7'd14);
            {7'd13, "M"}: a = arc_to(7'd15);
            {7'd13, "P"}: a = arc_cmd(6'd22);
            {7'd13, "D"}: a = arc_to(7'd16);
            {7'd13, "W"}: a = arc_to(7'd17);
            {7'd13, "S"}: a = arc_to(7'd18);
            {7'd13, "L"}: a = arc_to(7'd19);
            {7'd13, "I"}: a = arc_to(7'd21);
            {7'd13, "B"}: a = arc_cmd(6'd31);
            {7'd13, "G"}: a = arc_cmd(6'd32);
            {7'd13, "V"}: a = arc_cmd(6'd33);
            {7'd13, "T"}: a = arc_cmd(6'd34);
            {7'd13, "C"}: a = arc_cmd(6'd35);
            {7'd14, "R"}: a = arc_cmd(6'd19);
            {7'd14, "S"}: a = arc_cmd(6'd20);
            {7'd15, "S"}: a = arc_cmd(6'd21);
            {7'd16, "T"}: a = arc_cmd(6'd24);
            {7'd17, "D"}: a = arc_cmd(6'd25);
            {7'd17, "R"}: a = arc_cmd(6'd26);
            {7'd18, "D"}: a = arc_cmd(6'd27);
            {7'd18, "R"}: a = arc_cmd(6'd28);
            {7'd19, "E"}: a = arc_to(7'd20);
            {7'd20, "D"}: a = arc_cmd(6'd29);
            {7'd21, "D"}: a = arc_cmd(6'd30);
            {7'd22, "S"}: a = arc_cmd(6'd36);
            {7'd22, "E"}: a = arc_to(7'd23);
            {7'd23, "S"}: a = arc_to(7'd24);
            {7'd24, "E"}: a = arc_to(7'd25);
            {7'd25, "T"}: a = arc_cmd(6'd36);
            {7'd26, "O"}: a = arc_to(7'd27);
            {7'd26, "A"}: a = arc_to(7'd32);
            {7'd26, "S"}: a = arc_to(7'd33);
            {7'd26, "L"}: a = arc_to(7'd34);
            {7'd26, "I"}: a = arc_to(7'd36);
            {7'd26, "B"}: a = arc_cmd(6'd45);
            {7'd26, "G"}: a = arc_cmd(6'd46);
            {7'd27, "N"}: a = arc_to(7'd28);
            {7'd28, "F"}: a = arc_to(7'd29);
            {7'd29, "I"}: a = arc_to(7'd30);
            {7'd30, "R"}: a = arc_to(7'd31);
            {7'd31, "M"}: a = arc_cmd(6'd38);
            {7'd32, "R"}: a = arc_cmd(6'd39);
            {7'd32, "S"}: a = arc_cmd(6'd40);
            {7'd33, "D"}: a = arc_cmd(6'd41);
            {7'd33, "R"}: a = arc_cmd(6'd42);
            {7'd34, "E"}: a = arc_to(7'd35);
            {7'd35, "D"}: a = arc_cmd(6'd43);
            {7'd36, "D"}: a = arc_cmd(6'd44);
            default:      a = '0;
        endcase
        return a;
    endfunction

    // command named by an interior node when the word stops there
    function automatic node_acc_t node_accept(input logic [6:0] node);
        node_acc_t r;
        r = '0;
        case (node)
            7'd1:    r = '{hit: 1'b1, cmd: 6'd0};
            7'd3:    r = '{hit: 1'b1, cmd: 6'd5};
            7'd13:   r = '{hit: 1'b1, cmd: 6'd16};
            7'd14:   r = '{hit: 1'b1, cmd: 6'd18};
            7'd16:   r = '{hit: 1'b1, cmd: 6'd23};
            7'd27:   r = '{hit: 1'b1, cmd: 6'd37};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic parse_state_t after_cmd(input parse_state_t s, input logic [7:0] c);
        parse_state_t n;
        n = s;
        if (is_digit(c))
        begin
            n.val_acc = {28'd0, 4'(c - CHAR_ZERO)};
            n.phase   = PH_VALUE;
        end
        else if (c == CHAR_MINUS)
        begin
            n.val_neg = 1'b1;
            n.phase   = PH_VALUE;
        end
        else
        begin
            n.phase = PH_END_NOVAL;
        end
        return n;
    endfunction

    function automatic parse_state_t trie_feed(input parse_state_t s, input logic [7:0] c);
        parse_state_t n;
        logic [7:0]   u;
        trie_arc_t    a;
        node_acc_t    acc;
        n = s;
        u = c;
        if (c inside {[8'h61:8'h7A]})
            u = c - 8'd32;
        if (u inside {[8'h41:8'h5A]})
        begin
            a = trie_arc(s.node, u);
            if (!a.hit)
                n.bad = 1'b1;
            else if (a.leaf)
            begin
                n.cmd   = a.dest[5:0];
                n.phase = PH_AFTER;
            end
            else
            begin
                n.node = a.dest;
            end
        end
        else
        begin
            acc = node_accept(s.node);
            if (!acc.hit)
                n.bad = 1'b1;
            else
            begin
                n.cmd   = acc.cmd;
                n.phase = PH_AFTER;
                n       = after_cmd(n, c);
            end
        end
        return n;
    endfunction

    // one byte through the parser
    function automatic parse_state_t feed(input parse_state_t s, input logic [7:0] c);
        parse_state_t n;
        logic [3:0]   d;
        logic [12:0]  id_t;
        logic [35:0]  val_t;
        n     = s;
        d     = 4'(c - CHAR_ZERO);
        id_t  = {s.id_acc, 3'b000} + {3'b000, s.id_acc, 1'b0} + {9'd0, d};
        val_t = {1'b0, s.val_acc, 3'b000} + {3'b000, s.val_acc, 1'b0} + {32'd0, d};
        if (!s.bad)
        begin
            case (s.phase)
                PH_ID_FIRST:
                begin
                    if (is_digit(c))
                    begin
                        n.id_acc = {5'd0, d};
                        n.phase  = PH_ID;
                    end
                    else
                        n.bad = 1'b1;
                end
                PH_ID:
                begin
                    if (is_digit(c))
                        n.id_acc = (id_t > {4'd0, ID_LIMIT}) ? ID_LIMIT : id_t[8:0];
                    else
                    begin
                        n.phase = PH_TRIE;
                        n.node  = 7'd0;
                        n       = trie_feed(n, c);
                    end
                end
                PH_TRIE:  n = trie_feed(s, c);
                PH_AFTER: n = after_cmd(s, c);
                PH_VALUE:
                begin
                    if (is_digit(c))
                        n.val_acc = (val_t > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : val_t[31:0];
                    else
                        n.phase = PH_END_VAL;
                end
                default: n = s;
            endcase
        end
        return n;
    endfunction

    function automatic scpp_result_t make_result(input parse_state_t s);
        scpp_result_t r;
        logic         present;
        r       = '0;
        present = (s.phase == PH_VALUE) || (s.phase == PH_END_VAL);
        r.ok    = !s.bad && !s.id_acc[8];
        if (r.ok)
        begin
            r.device_id     = s.id_acc[7:0];
            r.command_code  = s.cmd;
            r.value_present = present;
            if (present)
            begin
                if (s.val_neg)
                    r.argument = 32'd0 - s.val_acc;
                else
                    r.argument = s.val_acc[31] ? POS_MAX : s.val_acc;
            end
        end
        return r;
    endfunction

endpackage

// File: sv/servo_command_packet_parser.sv
// ----------------------------------------------------------------------------
// servo_command_packet_parser: ASCII servo command packet parser
// Parses id, letter command and optional signed value, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte beat per clock cycle, with no bubbles between packets, unless
// a last byte stalls (see below); one step of the parse state per byte (one
// trie branch or one multiply-by-ten accumulate, plus the implied terminator on
// the last byte) sets that rate. A packet is a decimal device id, a
// case-insensitive command word from a fixed set of 48 (47 codes), and an
// optional signed decimal value; trailing bytes are ignored. Mark the last
// byte with packet_end: one result beat follows for that packet, taken into
// the result register from the input register once the result register has
// room, and none for other bytes. ok low means the packet was invalid (bad
// start, unknown command, id above 255) and then all other result fields read
// zero. The value saturates to the signed 32-bit range. Both channels are
// valid/ready; the input keeps taking bytes while a finished result waits
// downstream, and stalls only when a last byte finds the result register
// still full.
module servo_command_packet_parser (
    input  logic               clk,
    input  logic               rst_n,
    // byte channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_in,
    input  logic               packet_end,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               ok,
    output logic [7:0]         device_id,
    output logic [5:0]         command_code,
    output logic               value_present,
    output logic signed [31:0] argument
);
    import scpp_pkg::*;

    // finished result from the parse stage into the result register
    scpp_result_t res;
    logic         res_valid;
    logic         res_ready;

    // input register plus parse state, one byte stepped per cycle unless an end beat stalls
    scpp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .packet_end (packet_end),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // result register, splits the byte side from the result side
    scpp_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .device_id     (device_id),
        .command_code  (command_code),
        .value_present (value_present),
        .argument      (argument)
    );

endmodule

// File: sv/scpp_parse.sv
// ----------------------------------------------------------------------------
// scpp_parse: input register and parse state
// Registers each byte beat, then steps the parse state by one byte per cycle unless an end beat stalls.
// ----------------------------------------------------------------------------
module scpp_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            char_in,
    input  logic                  packet_end,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    output scpp_pkg::scpp_result_t res
);
    import scpp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   char_reg;
    logic         end_reg;
    parse_state_t state_reg, state_next;
    parse_state_t step_byte, step_term;
    logic         proc;

    // an end beat waits for room in the result register
    assign proc     = in_valid_reg && (!end_reg || res_ready);
    assign in_ready = !in_valid_reg || proc;

    always_comb
    begin
        step_byte = feed(state_reg, char_reg);
        step_term = feed(step_byte, 8'd0);
        res       = make_result(step_term);
        res_valid = in_valid_reg && end_reg;

        state_next = state_reg;
        if (proc)
            state_next = end_reg ? STATE_RESET : step_byte;

        in_valid_next = in_ready ? in_valid : in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
            end_reg  <= packet_end;
        end
    end

    a_reset_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        proc && end_reg |=> state_reg.phase == PH_ID_FIRST && !state_reg.bad)
        else $error("parse state not cleared after packet end");

    a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.node < NODE_COUNT)
        else $error("trie node out of range");

    a_id_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.id_acc <= ID_LIMIT)
        else $error("id accumulator above saturation limit");

    a_val_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.val_acc <= MAG_LIMIT)
        else $error("value magnitude above saturation limit");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !proc |=> $stable(state_reg) && in_valid_reg)
        else $error("parse state moved while byte stalled");

endmodule

// File: sv/scpp_out_buf.sv
// ----------------------------------------------------------------------------
// scpp_out_buf: result register
// Holds one packet result until the downstream side takes the beat.
// ----------------------------------------------------------------------------
module scpp_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    output logic                   res_ready,
    input  scpp_pkg::scpp_result_t res,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   ok,
    output logic [7:0]             device_id,
    output logic [5:0]             command_code,
    output logic                   value_present,
    output logic signed [31:0]     argument
);
    import scpp_pkg::*;

    logic         valid_reg, valid_next;
    scpp_result_t res_reg;
    logic         take;

    assign res_ready = !valid_reg || out_ready;
    assign take      = res_valid && res_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= res;
    end

    assign out_valid     = valid_reg;
    assign ok            = res_reg.ok;
    assign device_id     = res_reg.device_id;
    assign command_code  = res_reg.command_code;
    assign value_present = res_reg.value_present;
    assign argument      = res_reg.argument;

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_reg.ok |-> res_reg.device_id == 8'd0
            && res_reg.command_code == 6'd0 && !res_reg.value_present
            && res_reg.argument == 32'sd0)
        else $error("invalid packet result carries nonzero fields");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !res_reg.value_present |-> res_reg.argument == 32'sd0)
        else $error("argument nonzero without a value");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> res_reg.command_code <= 6'd46)
        else $error("command code out of range");

endmodule

// File: sim/servo_command_packet_parser_tb.sv
// ----------------------------------------------------------------------------
// servo_command_packet_parser_tb: self-checking bench for the packet parser
// Streams directed and random command packets through the byte channel with
// random gaps and result stalls, and checks every result beat against an
// in-bench model of the id / command trie / value parse.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module servo_command_packet_parser_tb;

    import scpp_pkg::*;

    // command numbers in trie order
    typedef enum logic [5:0] {
        CMD_L, CMD_LED, CMD_H, CMD_O, CMD_P, CMD_D, CMD_DEFAULT, CMD_AR, CMD_AS,
        CMD_MD, CMD_WD, CMD_WR, CMD_B, CMD_G, CMD_SD, CMD_SR, CMD_Q, CMD_QO,
        CMD_QA, CMD_QAR, CMD_QAS, CMD_QMS, CMD_QP, CMD_QD, CMD_QDT, CMD_QWD,
        CMD_QWR, CMD_QSD, CMD_QSR, CMD_QLED, CMD_QID, CMD_QB, CMD_QG, CMD_QV,
        CMD_QT, CMD_QC, CMD_RESET, CMD_CO, CMD_CONFIRM, CMD_CAR, CMD_CAS,
        CMD_CSD, CMD_CSR, CMD_CLED, CMD_CID, CMD_CB, CMD_CG
    } cmd_e;

    // where the model parse stands inside a packet
    typedef enum logic [2:0] {
        ST_ID_FIRST, ST_ID, ST_WORD, ST_AFTER, ST_VALUE, ST_DONE_NOVAL, ST_DONE_VAL
    } stage_e;

    typedef struct packed {
        stage_e      stage;
        logic [6:0]  node;
        logic [8:0]  id;
        logic [31:0] mag;
        logic        neg;
        logic [5:0]  cmd;
        logic        bad;
    } parse_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } beat_t;

    localparam parse_t PARSE_CLEAR = '{stage: ST_ID_FIRST, default: '0};
    localparam logic [7:0] CHAR_NUL  = 8'h00;
    localparam logic [7:0] CHAR_NINE = CHAR_ZERO + 8'd9;
    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam int         ARC_COUNT = 78;
    localparam int         SHOWN_MAX = 10;
    localparam int         RANDOM_BYTES = 1500;

    // trie arcs: {from node, uppercase letter, leaf flag, next node or command}
    function automatic logic [23:0] link(input int f, input logic [7:0] l, input int t);
        return {8'(f), l, 1'b0, 7'(t)};
    endfunction

    function automatic logic [23:0] term(input int f, input logic [7:0] l, input cmd_e c);
        return {8'(f), l, 2'b10, c};
    endfunction

    localparam logic [0:ARC_COUNT-1][23:0] ARCS = {
        link(0, "L", 1), term(0, "H", CMD_H), term(0, "O", CMD_O), term(0, "P", CMD_P),
        link(0, "D", 3), link(0, "A", 9), link(0, "M", 10), link(0, "W", 11),
        term(0, "B", CMD_B), term(0, "G", CMD_G), link(0, "S", 12), link(0, "Q", 13),
        link(0, "R", 22), link(0, "C", 26),
        link(1, "E", 2), term(2, "D", CMD_LED),
        link(3, "E", 4), link(4, "F", 5), link(5, "A", 6), link(6, "U", 7),
        link(7, "L", 8), term(8, "T", CMD_DEFAULT),
        term(9, "R", CMD_AR), term(9, "S", CMD_AS), term(10, "D", CMD_MD),
        term(11, "D", CMD_WD), term(11, "R", CMD_WR),
        term(12, "D", CMD_SD), term(12, "R", CMD_SR),
        term(13, "O", CMD_QO), link(13, "A", 14), link(13, "M", 15), term(13, "P", CMD_QP),
        link(13, "D", 16), link(13, "W", 17), link(13, "S", 18), link(13, "L", 19),
        link(13, "I", 21), term(13, "B", CMD_QB), term(13, "G", CMD_QG),
        term(13, "V", CMD_QV), term(13, "T", CMD_QT), term(13, "C", CMD_QC),
        term(14, "R", CMD_QAR), term(14, "S", CMD_QAS), term(15, "S", CMD_QMS),
        term(16, "T", CMD_QDT), term(17, "D", CMD_QWD), term(17, "R", CMD_QWR),
        term(18, "D", CMD_QSD), term(18, "R", CMD_QSR),
        link(19, "E", 20), term(20, "D", CMD_QLED), term(21, "D", CMD_QID),
        term(22, "S", CMD_RESET), link(22, "E", 23), link(23, "S", 24),
        link(24, "E", 25), term(25, "T", CMD_RESET),
        link(26, "O", 27), link(26, "A", 32), link(26, "S", 33), link(26, "L", 34),
        link(26, "I", 36), term(26, "B", CMD_CB), term(26, "G", CMD_CG),
        link(27, "N", 28), link(28, "F", 29), link(29, "I", 30), link(30, "R", 31),
        term(31, "M", CMD_CONFIRM),
        term(32, "R", CMD_CAR), term(32, "S", CMD_CAS),
        term(33, "D", CMD_CSD), term(33, "R", CMD_CSR),
        link(34, "E", 35), term(35, "D", CMD_CLED), term(36, "D", CMD_CID)
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         char_in = 8'h00;
    logic               packet_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               ok;
    logic [7:0]         device_id;
    logic [5:0]         command_code;
    logic               value_present;
    logic signed [31:0] argument;

    beat_t        tx_bytes[$];      // byte beats waiting for the driver
    scpp_result_t want_results[$];  // results predicted, not yet seen
    logic [7:0]   pkt[$];           // packet under construction
    parse_t       parser = PARSE_CLEAR;
    int           errors = 0;
    int           in_gap = 0;
    int           in_calm = 0;
    int           out_stall = 0;
    int           out_calm = 0;
    int           random_count = 0;

    servo_command_packet_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_in       (char_in),
        .packet_end    (packet_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ok            (ok),
        .device_id     (device_id),
        .command_code  (command_code),
        .value_present (value_present),
        .argument      (argument)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of the parse
    // ------------------------------------------------------------------------

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // returns {hit, leaf, next node or command}
    function automatic logic [8:0] find_arc(input logic [6:0] node, input logic [7:0] u);
        int i;
        for (i = 0; i < ARC_COUNT; i++)
            if (ARCS[i][23:16] == {1'b0, node} && ARCS[i][15:8] == u)
                return {1'b1, ARCS[i][7:0]};
        return '0;
    endfunction

    // command named by an interior node when the word stops there: {hit, command}
    function automatic logic [6:0] word_end(input logic [6:0] node);
        case (node)
            7'd1:    return {1'b1, CMD_L};
            7'd3:    return {1'b1, CMD_D};
            7'd13:   return {1'b1, CMD_Q};
            7'd14:   return {1'b1, CMD_QA};
            7'd16:   return {1'b1, CMD_QD};
            7'd27:   return {1'b1, CMD_CO};
            default: return '0;
        endcase
    endfunction

    // first byte after a complete command word
    function automatic parse_t start_value(input parse_t s, input logic [7:0] c);
        parse_t n;
        n = s;
        if (is_dec(c))
        begin
            n.mag   = 32'(c - CHAR_ZERO);
            n.stage = ST_VALUE;
        end
        else if (c == CHAR_MINUS)
        begin
            n.neg   = 1'b1;
            n.stage = ST_VALUE;
        end
        else
            n.stage = ST_DONE_NOVAL;
        return n;
    endfunction

    function automatic parse_t word_step(input parse_t s, input logic [7:0] c);
        parse_t     n;
        logic [7:0] u;
        logic [8:0] arc;
        logic [6:0] fin;
        n = s;
        u = c;
        if (c >= "a" && c <= "z")
            u = c - CASE_BIT;
        if (u >= "A" && u <= "Z")
        begin
            arc = find_arc(s.node, u);
            if (!arc[8])
                n.bad = 1'b1;
            else if (arc[7])
            begin
                n.cmd   = arc[5:0];
                n.stage = ST_AFTER;
            end
            else
                n.node = arc[6:0];
        end
        else
        begin
            fin = word_end(s.node);
            if (!fin[6])
                n.bad = 1'b1;
            else
            begin
                n.cmd   = fin[5:0];
                n.stage = ST_AFTER;
                n       = start_value(n, c);
            end
        end
        return n;
    endfunction

    function automatic parse_t parse_byte(input parse_t s, input logic [7:0] c);
        parse_t            n;
        logic [7:0]        digit;
        int unsigned       t;
        longint unsigned   v;
        n     = s;
        digit = c - CHAR_ZERO;
        if (s.bad)
            return n;
        case (s.stage)
            ST_ID_FIRST:
            begin
                if (is_dec(c))
                begin
                    n.id    = 9'(digit);
                    n.stage = ST_ID;
                end
                else
                    n.bad = 1'b1;
            end
            ST_ID:
            begin
                if (is_dec(c))
                begin
                    t    = 32'(s.id) * 10 + 32'(digit);
                    n.id = (t > 32'(ID_LIMIT)) ? ID_LIMIT : 9'(t);
                end
                else
                begin
                    n.stage = ST_WORD;
                    n.node  = 7'd0;
                    n       = word_step(n, c);
                end
            end
            ST_WORD:  n = word_step(s, c);
            ST_AFTER: n = start_value(s, c);
            ST_VALUE:
            begin
                if (is_dec(c))
                begin
                    v     = 64'(s.mag) * 10 + 64'(digit);
                    n.mag = (v > 64'(MAG_LIMIT)) ? MAG_LIMIT : 32'(v);
                end
                else
                    n.stage = ST_DONE_VAL;
            end
            default: ;
        endcase
        return n;
    endfunction

    function automatic scpp_result_t packet_result(input parse_t s);
        scpp_result_t r;
        logic         has;
        r   = '0;
        has = (s.stage == ST_VALUE) || (s.stage == ST_DONE_VAL);
        r.ok = !s.bad && (s.id < ID_LIMIT);
        if (r.ok)
        begin
            r.device_id     = s.id[7:0];
            r.command_code  = s.cmd;
            r.value_present = has;
            if (has)
                r.argument = s.neg ? 32'd0 - s.mag : ((s.mag > POS_MAX) ? POS_MAX : s.mag);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // gaps: mostly none or short, a few long, now and then a calm stretch
    // ------------------------------------------------------------------------
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // ------------------------------------------------------------------------
    // driver: one byte beat at a time from tx_bytes, model updated on accept
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            char_in    <= 8'h00;
            packet_end <= 1'b0;
            in_gap     <= 0;
            parser     = PARSE_CLEAR;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parser = parse_byte(parser, char_in);
                // last byte: implied terminator, then one result
                if (packet_end)
                begin
                    parser = parse_byte(parser, CHAR_NUL);
                    want_results.push_back(packet_result(parser));
                    parser = PARSE_CLEAR;
                end
            end
            // the slot is free unless a beat is still waiting for ready
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() > 0)
                begin
                    in_valid   <= 1'b1;
                    char_in    <= tx_bytes[0].ch;
                    packet_end <= tx_bytes[0].last;
                    void'(tx_bytes.pop_front());
                    in_gap     <= pick_gap(in_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random stalls on ready, every result beat checked in order
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_check
        scpp_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (want_results.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOWN_MAX)
                        $display("unexpected result: ok=%0b id=%0d cmd=%0d val=%0b arg=%0d",
                                 ok, device_id, command_code, value_present, argument);
                end
                else
                begin
                    want = want_results.pop_front();
                    if (want.ok !== ok || want.device_id !== device_id ||
                        want.command_code !== command_code ||
                        want.value_present !== value_present || want.argument !== argument)
                    begin
                        errors++;
                        if (errors <= SHOWN_MAX)
                        begin
                            $display("mismatch exp ok=%0b id=%0d cmd=%0d val=%0b arg=%0d",
                                     want.ok, want.device_id, want.command_code,
                                     want.value_present, want.argument);
                            $display("         got ok=%0b id=%0d cmd=%0d val=%0b arg=%0d",
                                     ok, device_id, command_code, value_present, argument);
                        end
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    out_stall <= pick_gap(out_calm);
            end
        end
    end

    // ------------------------------------------------------------------------
    // packet building
    // ------------------------------------------------------------------------
    function automatic string cmd_text(input cmd_e c);
        case (c)
            CMD_L: return "L";        CMD_LED: return "LED";      CMD_H: return "H";
            CMD_O: return "O";        CMD_P: return "P";          CMD_D: return "D";
            CMD_DEFAULT: return "DEFAULT";                        CMD_AR: return "AR";
            CMD_AS: return "AS";      CMD_MD: return "MD";        CMD_WD: return "WD";
            CMD_WR: return "WR";      CMD_B: return "B";          CMD_G: return "G";
            CMD_SD: return "SD";      CMD_SR: return "SR";        CMD_Q: return "Q";
            CMD_QO: return "QO";      CMD_QA: return "QA";        CMD_QAR: return "QAR";
            CMD_QAS: return "QAS";    CMD_QMS: return "QMS";      CMD_QP: return "QP";
            CMD_QD: return "QD";      CMD_QDT: return "QDT";      CMD_QWD: return "QWD";
            CMD_QWR: return "QWR";    CMD_QSD: return "QSD";      CMD_QSR: return "QSR";
            CMD_QLED: return "QLED";  CMD_QID: return "QID";      CMD_QB: return "QB";
            CMD_QG: return "QG";      CMD_QV: return "QV";        CMD_QT: return "QT";
            CMD_QC: return "QC";      CMD_RESET: return "RESET";  CMD_CO: return "CO";
            CMD_CONFIRM: return "CONFIRM";                        CMD_CAR: return "CAR";
            CMD_CAS: return "CAS";    CMD_CSD: return "CSD";      CMD_CSR: return "CSR";
            CMD_CLED: return "CLED";  CMD_CID: return "CID";      CMD_CB: return "CB";
            default: return "CG";
        endcase
    endfunction

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            pkt.push_back(s[i]);
    endtask

    // letters in random case
    task automatic put_word(input string s);
        int         i;
        logic [7:0] c;
        for (i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
                c = c | CASE_BIT;
            pkt.push_back(c);
        end
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++)
            tx_bytes.push_back('{ch: pkt[i], last: (i == pkt.size() - 1)});
        pkt.delete();
    endtask

    task automatic send_text(input string s);
        put_text(s);
        send_packet();
    endtask

    task automatic add_random_packet();
        int          kind;
        int          n;
        int          k;
        int unsigned v;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            // raw noise over the whole byte range
            n = $urandom_range(1, 6);
            repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
            random_count += pkt.size();
            send_packet();
            return;
        end
        // device id, now and then a leading zero or an oversize id
        if ($urandom_range(0, 9) == 0)
            v = $urandom_range(256, 99999);
        else
            v = $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0)
            put_text("0");
        put_text($sformatf("%0d", v));
        // command word, a few of them made-up letters
        if (kind < 18)
        begin
            n = $urandom_range(1, 3);
            repeat (n) pkt.push_back(8'($urandom_range("A", "Z")) |
                                     ($urandom_range(0, 1) ? CASE_BIT : 8'h00));
        end
        else
        begin
            k = $urandom_range(0, 47);
            put_word((k == 47) ? "RS" : cmd_text(cmd_e'(k)));
        end
        // optional signed value
        if ($urandom_range(0, 99) >= 30)
        begin
            if ($urandom_range(0, 9) < 4)
                put_text("-");
            case ($urandom_range(0, 9))
                0:       ;
                6:       put_text($sformatf("%0d", $urandom));
                7:
                begin
                    case ($urandom_range(0, 2))
                        0:       put_text("2147483647");
                        1:       put_text("2147483648");
                        default: put_text("2147483649");
                    endcase
                end
                8:
                begin
                    n = $urandom_range(10, 14);
                    repeat (n) pkt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
                9:       put_text("0");
                default: put_text($sformatf("%0d", $urandom_range(0, 999)));
            endcase
        end
        // trailing junk
        if ($urandom_range(0, 99) < 30)
        begin
            n = $urandom_range(1, 3);
            repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
        end
        // cut short now and then
        if ($urandom_range(0, 99) < 8 && pkt.size() > 1)
        begin
            n = $urandom_range(1, pkt.size() - 1);
            repeat (n) void'(pkt.pop_back());
        end
        random_count += pkt.size();
        send_packet();
    endtask

    // sender holds off until every result is in
    task automatic drain();
        @(negedge clk);
        while (tx_bytes.size() != 0 || in_valid || want_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed packets
        send_text("0l");                 // smallest id, interior node ends word
        send_text("255QAR-");            // largest id, bare minus
        send_text("256H7");              // id above 255
        send_text("99999P");             // id saturates
        send_text("AL");                 // bad start
        send_text("1Z");                 // unknown letter at the root
        send_text("1LE5");               // word stops at a node with no command
        put_text("9D");                  // zero byte ends the word
        pkt.push_back(CHAR_NUL);
        send_text("7");
        send_text("3O2147483648");       // positive value clamps
        send_text("3o-99999999999");     // negative value clamps
        send_text("3o-2147483648");
        send_text("12ReSeT42x!");        // trailing junk ignored
        put_text("1q");                  // high byte is a non-letter
        pkt.push_back(8'hC1);
        send_packet();
        send_text("2cOnFiRm7");
        send_text("4default-0");
        send_text("5");                  // id only, no command
        drain();

        // random packets, with a full drain halfway through
        while (random_count < RANDOM_BYTES / 2)
            add_random_packet();
        drain();
        while (random_count < RANDOM_BYTES)
            add_random_packet();
        drain();

        repeat (10) @(posedge clk);
        if (errors == 0 && want_results.size() == 0)
            $display("servo_command_packet_parser_tb OK");
        else
            $display("servo_command_packet_parser_tb NOT OK");
        $finish;
    end

    // hang guard
    initial
    begin
        #5_000_000;
        $display("servo_command_packet_parser_tb NOT OK");
        $finish;
    end

endmodule
